>>> rtl/lrtc_pkg.sv
// Package for the link retry timer controller: command, frame, close and
// link-state codes, configuration reset values and the structs used by lrtc_step, the top level and tb.
// No dependencies.
package lrtc_pkg;

  typedef enum logic [2:0] {
    CMD_TICK     = 3'd0,
    CMD_T1       = 3'd1,
    CMD_SET_LINK = 3'd2,
    CMD_FRAME    = 3'd3,
    CMD_RX_BUSY  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    FR_NONE  = 3'd0,
    FR_SABM  = 3'd1,
    FR_SABME = 3'd2,
    FR_DISC  = 3'd3,
    FR_DM    = 3'd4
  } frame_e;

  typedef enum logic [1:0] {
    CLOSE_NONE    = 2'd0,
    CLOSE_NORMAL  = 2'd1,
    CLOSE_TIMEOUT = 2'd2
  } close_e;

  typedef enum logic [2:0] {
    LS_DISCONNECTED  = 3'd0,
    LS_CONNECTING    = 3'd1,
    LS_DISCONNECTING = 3'd2,
    LS_CONNECTED     = 3'd3,
    LS_RECOVERY      = 3'd4
  } link_e;

  typedef enum logic [2:0] {
    CFG_MAX_RETRIES    = 3'd0,
    CFG_T3_PERIOD      = 3'd1,
    CFG_IDLE_PERIOD    = 3'd2,
    CFG_DEFAULT_WINDOW = 3'd3,
    CFG_RX_BUFFER_SIZE = 3'd4
  } cfg_idx_e;

  localparam logic [4:0]  MaxRetriesRst    = 5'd10;
  localparam logic [15:0] T3PeriodRst      = 16'd1800;
  localparam logic [15:0] IdlePeriodRst    = 16'd0;
  localparam logic [6:0]  DefaultWindowRst = 7'd2;
  localparam logic [15:0] RxBufferSizeRst  = 16'd32768;
  localparam logic [6:0]  WindowRst        = 7'd2;

  typedef struct packed {
    logic [4:0]  max_retries;
    logic [15:0] t3_period;
    logic [15:0] idle_period;
    logic [6:0]  default_window;
    logic [15:0] rx_buffer_size;
  } cfg_t;

  typedef struct packed {
    link_e       link_state;
    logic [4:0]  retry_count;
    logic        extended_mode;
    logic [6:0]  window_size;
    logic [15:0] t3_count;
    logic [15:0] idle_count;
    logic        rx_busy;
  } state_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [2:0]  new_state;
    logic        use_extended;
    logic        is_info_frame;
    logic [15:0] rx_used;
    logic [15:0] t1_value;
  } item_t;

  typedef struct packed {
    frame_e      send_frame;
    logic        link_failed;
    logic        clear_queues;
    close_e      close_kind;
    logic        dama_off;
    logic        t1_restart;
    logic [15:0] t1_reload;
    logic [2:0]  link_state_out;
    logic        extended_out;
    logic [6:0]  window_out;
    logic [4:0]  retry_out;
    logic        rx_busy_cleared;
  } result_t;

endpackage

>>> rtl/lrtc_step.sv
// Next-state and result logic for one command of the link retry timer controller.
// Purely combinational; uses lrtc_pkg.
module lrtc_step import lrtc_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  logic   exhausted;
  logic   t3_fired;
  state_t st;

  assign exhausted = (state_i.retry_count == cfg_i.max_retries);

  always_comb begin
    st        = state_i;
    t3_fired  = 1'b0;
    result_o  = '0;

    case (cmd_e'(item_i.command))
      CMD_TICK: begin
        if ((state_i.link_state == LS_CONNECTED || state_i.link_state == LS_RECOVERY) &&
            (item_i.rx_used < {1'b0, cfg_i.rx_buffer_size[15:1]}) && state_i.rx_busy) begin
          st.rx_busy               = 1'b0;
          result_o.rx_busy_cleared = 1'b1;
        end
        if (state_i.t3_count != 16'd0) begin
          st.t3_count = state_i.t3_count - 16'd1;
          if (state_i.t3_count == 16'd1) begin
            // T3 ran out: disconnect on timeout
            result_o.link_failed  = 1'b1;
            result_o.clear_queues = 1'b1;
            result_o.send_frame   = FR_DISC;
            result_o.dama_off     = 1'b1;
            result_o.close_kind   = CLOSE_TIMEOUT;
            st.link_state         = LS_DISCONNECTED;
            t3_fired              = 1'b1;
          end
        end
        if (!t3_fired && state_i.idle_count != 16'd0) begin
          st.idle_count = state_i.idle_count - 16'd1;
          if (state_i.idle_count == 16'd1) begin
            result_o.clear_queues = 1'b1;
            result_o.t1_restart   = 1'b1;
            result_o.t1_reload    = item_i.t1_value;
            result_o.close_kind   = CLOSE_NORMAL;
            st.retry_count        = 5'd0;
            st.t3_count           = cfg_i.t3_period;
            st.link_state = (state_i.link_state == LS_CONNECTING ||
                             state_i.link_state == LS_DISCONNECTING) ?
                            LS_DISCONNECTED : LS_DISCONNECTING;
          end
        end
      end

      CMD_T1: begin
        result_o.t1_restart = 1'b1;
        result_o.t1_reload  = item_i.t1_value;
        case (state_i.link_state)
          LS_CONNECTING: begin
            if (exhausted) begin
              if (!state_i.extended_mode) begin
                result_o.link_failed  = 1'b1;
                result_o.clear_queues = 1'b1;
                result_o.close_kind   = CLOSE_TIMEOUT;
                st.link_state         = LS_DISCONNECTED;
              end else begin
                // fall back to standard modulus and retry from scratch
                st.extended_mode    = 1'b0;
                st.window_size      = cfg_i.default_window;
                st.retry_count      = 5'd0;
                result_o.send_frame = FR_SABM;
              end
            end else begin
              st.retry_count      = state_i.retry_count + 5'd1;
              result_o.send_frame = state_i.extended_mode ? FR_SABME : FR_SABM;
            end
          end
          LS_DISCONNECTING: begin
            if (exhausted) begin
              result_o.link_failed  = 1'b1;
              result_o.clear_queues = 1'b1;
              result_o.send_frame   = FR_DISC;
              result_o.close_kind   = CLOSE_TIMEOUT;
              st.link_state         = LS_DISCONNECTED;
            end else begin
              st.retry_count = state_i.retry_count + 5'd1;
            end
          end
          LS_CONNECTED: begin
            st.retry_count = 5'd1;
            st.link_state  = LS_RECOVERY;
          end
          LS_RECOVERY: begin
            if (exhausted) begin
              result_o.link_failed  = 1'b1;
              result_o.clear_queues = 1'b1;
              result_o.send_frame   = FR_DM;
              result_o.close_kind   = CLOSE_TIMEOUT;
              st.link_state         = LS_DISCONNECTED;
            end else begin
              st.retry_count = state_i.retry_count + 5'd1;
            end
          end
          default: ;
        endcase
      end

      CMD_SET_LINK: begin
        if (item_i.new_state <= LS_RECOVERY) begin
          st.link_state    = link_e'(item_i.new_state);
          st.extended_mode = item_i.use_extended;
          st.window_size   = cfg_i.default_window;
          st.retry_count   = 5'd0;
        end
      end

      CMD_FRAME: begin
        st.t3_count = cfg_i.t3_period;
        if (item_i.is_info_frame) begin
          st.idle_count = cfg_i.idle_period;
        end
      end

      CMD_RX_BUSY: begin
        st.rx_busy = 1'b1;
      end

      default: ;
    endcase

    result_o.link_state_out = st.link_state;
    result_o.extended_out   = st.extended_mode;
    result_o.window_out     = st.window_size;
    result_o.retry_out      = st.retry_count;
  end

  assign state_o = st;

endmodule

>>> rtl/link_retry_timer_controller.sv
// Link retry timer controller, top level: input register, state registers,
// result register and configuration registers. Uses lrtc_pkg and lrtc_step.
//
// One command per cycle while the result channel is not stalled: a command
// transferred on the input channel is held in the input register, is applied
// to the link state by the step logic and lands in the result register, and
// back-to-back commands give one result every cycle while out_ready_i is high.
// The input register and the result register part the two channels:
// new commands keep being taken while a result waits, and only when both
// registers are full does in_ready_o follow out_ready_i. Each command gives
// exactly one result. Configuration writes take effect at the next edge and
// should only be made while no command is in flight.
module link_retry_timer_controller import lrtc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // command channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  command_i,
  input  logic [2:0]  new_state_i,
  input  logic        use_extended_i,
  input  logic        is_info_frame_i,
  input  logic [15:0] rx_used_i,
  input  logic [15:0] t1_value_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  send_frame_o,
  output logic        link_failed_o,
  output logic        clear_queues_o,
  output logic [1:0]  close_kind_o,
  output logic        dama_off_o,
  output logic        t1_restart_o,
  output logic [15:0] t1_reload_o,
  output logic [2:0]  link_state_out_o,
  output logic        extended_out_o,
  output logic [6:0]  window_out_o,
  output logic [4:0]  retry_out_o,
  output logic        rx_busy_cleared_o
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  item_t   item_q;
  logic    in_valid_q;
  result_t result_q, result_d;
  logic    out_valid_q;

  logic in_xfer;   // command transfer into the input register
  logic step_en;   // held command is applied and moves to the result register

  assign step_en    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step_en;
  assign in_xfer    = in_valid_i && in_ready_o;

  // ---------------- configuration registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_retries    <= MaxRetriesRst;
      cfg_q.t3_period      <= T3PeriodRst;
      cfg_q.idle_period    <= IdlePeriodRst;
      cfg_q.default_window <= DefaultWindowRst;
      cfg_q.rx_buffer_size <= RxBufferSizeRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_RETRIES:    cfg_q.max_retries    <= cfg_wdata_i[4:0];
        CFG_T3_PERIOD:      cfg_q.t3_period      <= cfg_wdata_i;
        CFG_IDLE_PERIOD:    cfg_q.idle_period    <= cfg_wdata_i;
        CFG_DEFAULT_WINDOW: cfg_q.default_window <= cfg_wdata_i[6:0];
        CFG_RX_BUFFER_SIZE: cfg_q.rx_buffer_size <= cfg_wdata_i;
        default: ;  // indexes past the register list are dropped
      endcase
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q.command       <= command_i;
      item_q.new_state     <= new_state_i;
      item_q.use_extended  <= use_extended_i;
      item_q.is_info_frame <= is_info_frame_i;
      item_q.rx_used       <= rx_used_i;
      item_q.t1_value      <= t1_value_i;
    end
  end

  // ---------------- step logic ----------------
  lrtc_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // link state only moves when a command is applied
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.link_state    <= LS_DISCONNECTED;
      state_q.retry_count   <= 5'd0;
      state_q.extended_mode <= 1'b0;
      state_q.window_size   <= WindowRst;
      state_q.t3_count      <= 16'd0;
      state_q.idle_count    <= 16'd0;
      state_q.rx_busy       <= 1'b0;
    end else if (step_en) begin
      state_q <= state_d;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_en) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign send_frame_o      = result_q.send_frame;
  assign link_failed_o     = result_q.link_failed;
  assign clear_queues_o    = result_q.clear_queues;
  assign close_kind_o      = result_q.close_kind;
  assign dama_off_o        = result_q.dama_off;
  assign t1_restart_o      = result_q.t1_restart;
  assign t1_reload_o       = result_q.t1_reload;
  assign link_state_out_o  = result_q.link_state_out;
  assign extended_out_o    = result_q.extended_out;
  assign window_out_o      = result_q.window_out;
  assign retry_out_o       = result_q.retry_out;
  assign rx_busy_cleared_o = result_q.rx_busy_cleared;

endmodule

>>> rtl/lrtc_checker.sv
// Port-level assertions for the link retry timer controller, bound to the top level.
// Uses lrtc_pkg; depends on link_retry_timer_controller for the bind.
module lrtc_checker import lrtc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  send_frame_o,
  input logic        link_failed_o,
  input logic [1:0]  close_kind_o,
  input logic        dama_off_o,
  input logic        t1_restart_o,
  input logic [15:0] t1_reload_o,
  input logic [2:0]  link_state_out_o,
  input logic        extended_out_o
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // reload value is zero unless T1 is restarted
  a_reload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !t1_restart_o |-> t1_reload_o == 16'd0)
    else $error("t1_reload without t1_restart");

  // link failure always ends disconnected with a timeout close
  a_fail_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && link_failed_o |->
      link_state_out_o == LS_DISCONNECTED && close_kind_o == CLOSE_TIMEOUT)
    else $error("link failure with wrong state or close kind");

  // DAMA off only comes with the T3 timeout DISC
  a_dama_disc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dama_off_o |-> send_frame_o == FR_DISC && link_failed_o)
    else $error("dama_off without T3 disconnect");

  // SABME only while the extended modulus is kept
  a_sabme_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_frame_o == FR_SABME |-> extended_out_o)
    else $error("SABME sent in standard modulus");

endmodule

bind link_retry_timer_controller lrtc_checker u_lrtc_checker (.*);

>>> tb/sv/tb.sv
// Testbench for the link retry timer controller: directed table, then random phases
// under several register settings, checked against an in-bench predictor.
// Depends on lrtc_pkg and link_retry_timer_controller.
`timescale 1ns / 100ps

module tb;
  import lrtc_pkg::*;

  // Command and link-state codes the package leaves undefined; the block must
  // ignore them (reserved commands) or drop the whole set-link (bad state).
  localparam logic [2:0] CMD_RSVD_LO = 3'd5;
  localparam logic [2:0] CMD_RSVD_HI = 3'd7;
  localparam logic [2:0] LS_BAD_LO   = 3'd5;
  localparam logic [2:0] LS_BAD_HI   = 3'd7;

  localparam int NUM_PHASES  = 10;
  localparam int PHASE_ITEMS = 63;
  localparam int LONG_HOLD   = 64;    // receiver hold-off, long enough to back up the input
  localparam int STALL_LIMIT = 2000;  // cycles with no transfer on either channel
  localparam int REPORT_MAX  = 10;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_MAX_RETRIES;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [2:0]  command_i = CMD_TICK;
  logic [2:0]  new_state_i = '0;
  logic        use_extended_i = 1'b0;
  logic        is_info_frame_i = 1'b0;
  logic [15:0] rx_used_i = '0;
  logic [15:0] t1_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  send_frame_o;
  logic        link_failed_o;
  logic        clear_queues_o;
  logic [1:0]  close_kind_o;
  logic        dama_off_o;
  logic        t1_restart_o;
  logic [15:0] t1_reload_o;
  logic [2:0]  link_state_out_o;
  logic        extended_out_o;
  logic [6:0]  window_out_o;
  logic [4:0]  retry_out_o;
  logic        rx_busy_cleared_o;

  link_retry_timer_controller u_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .new_state_i,
    .use_extended_i,
    .is_info_frame_i,
    .rx_used_i,
    .t1_value_i,
    .out_valid_o,
    .out_ready_i,
    .send_frame_o,
    .link_failed_o,
    .clear_queues_o,
    .close_kind_o,
    .dama_off_o,
    .t1_restart_o,
    .t1_reload_o,
    .link_state_out_o,
    .extended_out_o,
    .window_out_o,
    .retry_out_o,
    .rx_busy_cleared_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor: a private copy of the link state and the register settings.
  // ---------------------------------------------------------------------------
  link_e       lk_state;
  logic [4:0]  lk_retry;
  logic        lk_ext;
  logic [6:0]  lk_window;
  logic [15:0] lk_t3;
  logic [15:0] lk_idle;
  logic        lk_rx_busy;

  logic [4:0]  cf_max_retries;
  logic [15:0] cf_t3_period;
  logic [15:0] cf_idle_period;
  logic [6:0]  cf_default_window;
  logic [15:0] cf_rx_buf;

  result_t link_report_q[$];   // link reports still owed by the block

  int unsigned items_sent, reports_ok, mismatches;
  int unsigned timeouts_seen, closes_seen, busy_clears;
  int          hold_left, stall_cycles, idle_pct;
  bit          long_hold_req;

  // Applies one command to the private link copy and returns the report it owes.
  function automatic result_t link_ctrl_next(item_t it);
    result_t r;
    bit      t3_fired;
    bit      spent;
    r = '0;
    t3_fired = 1'b0;
    spent = (lk_retry == cf_max_retries);
    case (it.command)
      CMD_TICK: begin
        // own receive busy drains once occupancy drops below half the buffer
        if ((lk_state == LS_CONNECTED || lk_state == LS_RECOVERY) &&
            it.rx_used < (cf_rx_buf >> 1) && lk_rx_busy) begin
          lk_rx_busy = 1'b0;
          r.rx_busy_cleared = 1'b1;
        end
        if (lk_t3 != '0) begin
          lk_t3 = lk_t3 - 16'd1;
          if (lk_t3 == '0) begin
            r.link_failed  = 1'b1;
            r.clear_queues = 1'b1;
            r.send_frame   = FR_DISC;
            r.dama_off     = 1'b1;
            r.close_kind   = CLOSE_TIMEOUT;
            lk_state = LS_DISCONNECTED;
            t3_fired = 1'b1;
          end
        end
        // T3 expiry takes the whole tick: idle countdown is left alone
        if (!t3_fired && lk_idle != '0) begin
          lk_idle = lk_idle - 16'd1;
          if (lk_idle == '0) begin
            r.clear_queues = 1'b1;
            r.t1_restart   = 1'b1;
            r.t1_reload    = it.t1_value;
            r.close_kind   = CLOSE_NORMAL;
            lk_retry = '0;
            lk_t3    = cf_t3_period;
            lk_state = (lk_state == LS_CONNECTING || lk_state == LS_DISCONNECTING) ?
                       LS_DISCONNECTED : LS_DISCONNECTING;
          end
        end
      end
      CMD_T1: begin
        case (lk_state)
          LS_CONNECTING: begin
            if (spent && !lk_ext) begin
              r.link_failed  = 1'b1;
              r.clear_queues = 1'b1;
              r.close_kind   = CLOSE_TIMEOUT;
              lk_state = LS_DISCONNECTED;
            end else if (spent) begin
              // N2 ran out on an extended connect: retry with the standard modulus
              lk_ext    = 1'b0;
              lk_window = cf_default_window;
              lk_retry  = '0;
              r.send_frame = FR_SABM;
            end else begin
              lk_retry = lk_retry + 5'd1;
              r.send_frame = lk_ext ? FR_SABME : FR_SABM;
            end
          end
          LS_DISCONNECTING: begin
            if (spent) begin
              r.link_failed  = 1'b1;
              r.clear_queues = 1'b1;
              r.send_frame   = FR_DISC;
              r.close_kind   = CLOSE_TIMEOUT;
              lk_state = LS_DISCONNECTED;
            end else begin
              lk_retry = lk_retry + 5'd1;
            end
          end
          LS_CONNECTED: begin
            lk_retry = 5'd1;
            lk_state = LS_RECOVERY;
          end
          LS_RECOVERY: begin
            if (spent) begin
              r.link_failed  = 1'b1;
              r.clear_queues = 1'b1;
              r.send_frame   = FR_DM;
              r.close_kind   = CLOSE_TIMEOUT;
              lk_state = LS_DISCONNECTED;
            end else begin
              lk_retry = lk_retry + 5'd1;
            end
          end
          default: ;
        endcase
        r.t1_restart = 1'b1;
        r.t1_reload  = it.t1_value;
      end
      CMD_SET_LINK: begin
        if (it.new_state <= LS_RECOVERY) begin
          lk_state  = link_e'(it.new_state);
          lk_ext    = it.use_extended;
          lk_window = cf_default_window;
          lk_retry  = '0;
        end
      end
      CMD_FRAME: begin
        lk_t3 = cf_t3_period;
        if (it.is_info_frame) lk_idle = cf_idle_period;
      end
      CMD_RX_BUSY: lk_rx_busy = 1'b1;
      default: ;
    endcase
    r.link_state_out = lk_state;
    r.extended_out   = lk_ext;
    r.window_out     = lk_window;
    r.retry_out      = lk_retry;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: check, then decide ready for the next edge.
  // ---------------------------------------------------------------------------
  task automatic note_error(string msg);
    if (mismatches < REPORT_MAX) $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_report();
    result_t got;
    result_t want;
    string   bad;
    got.send_frame      = frame_e'(send_frame_o);
    got.link_failed     = link_failed_o;
    got.clear_queues    = clear_queues_o;
    got.close_kind      = close_e'(close_kind_o);
    got.dama_off        = dama_off_o;
    got.t1_restart      = t1_restart_o;
    got.t1_reload       = t1_reload_o;
    got.link_state_out  = link_state_out_o;
    got.extended_out    = extended_out_o;
    got.window_out      = window_out_o;
    got.retry_out       = retry_out_o;
    got.rx_busy_cleared = rx_busy_cleared_o;
    if (link_report_q.size() == 0) begin
      note_error($sformatf("report with nothing owed: %h", got));
      return;
    end
    want = link_report_q.pop_front();
    bad = "";
    if (got.send_frame !== want.send_frame) bad = {bad, " send_frame"};
    if (got.link_failed !== want.link_failed) bad = {bad, " link_failed"};
    if (got.clear_queues !== want.clear_queues) bad = {bad, " clear_queues"};
    if (got.close_kind !== want.close_kind) bad = {bad, " close_kind"};
    if (got.dama_off !== want.dama_off) bad = {bad, " dama_off"};
    if (got.t1_restart !== want.t1_restart) bad = {bad, " t1_restart"};
    if (got.t1_reload !== want.t1_reload) bad = {bad, " t1_reload"};
    if (got.link_state_out !== want.link_state_out) bad = {bad, " link_state"};
    if (got.extended_out !== want.extended_out) bad = {bad, " extended"};
    if (got.window_out !== want.window_out) bad = {bad, " window"};
    if (got.retry_out !== want.retry_out) bad = {bad, " retry"};
    if (got.rx_busy_cleared !== want.rx_busy_cleared) bad = {bad, " rx_busy_cleared"};
    if (bad != "") note_error($sformatf("fields%s: exp %h got %h", bad, want, got));
    else reports_ok++;
    if (want.close_kind == CLOSE_TIMEOUT) timeouts_seen++;
    if (want.close_kind == CLOSE_NORMAL) closes_seen++;
    if (want.rx_busy_cleared) busy_clears++;
  endtask

  // The long hold-off is counted here; the stimulus only asks for it.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_report();
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        out_ready_i <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        hold_left = $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if neither channel moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d reports owed",
               STALL_LIMIT, link_report_q.size());
      $display("link_retry_timer_controller test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // Offers one command, holds it until transfer, then books the owed report.
  task automatic send_item(item_t it, bit typed, result_t typed_res);
    result_t r;
    in_valid_i      <= 1'b1;
    command_i       <= it.command;
    new_state_i     <= it.new_state;
    use_extended_i  <= it.use_extended;
    is_info_frame_i <= it.is_info_frame;
    rx_used_i       <= it.rx_used;
    t1_value_i      <= it.t1_value;
    do @(posedge clk_i); while (!in_ready_o);
    r = link_ctrl_next(it);
    link_report_q.push_back(typed ? typed_res : r);
    items_sent++;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Stops offering and waits until every owed report is back.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (link_report_q.size() != 0);
  endtask

  task automatic put_reg(cfg_idx_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  // Only while idle; narrow registers keep the low bits of the write data.
  task automatic apply_settings(logic [15:0] mr, logic [15:0] t3, logic [15:0] idl,
                                logic [15:0] dw, logic [15:0] rxb);
    drain();
    repeat (2) @(posedge clk_i);
    put_reg(CFG_MAX_RETRIES, mr);
    put_reg(CFG_T3_PERIOD, t3);
    put_reg(CFG_IDLE_PERIOD, idl);
    put_reg(CFG_DEFAULT_WINDOW, dw);
    put_reg(CFG_RX_BUFFER_SIZE, rxb);
    cfg_we_i <= 1'b0;
    cf_max_retries    = mr[4:0];
    cf_t3_period      = t3;
    cf_idle_period    = idl;
    cf_default_window = dw[6:0];
    cf_rx_buf         = rxb;
  endtask

  // Random command, weighted toward the timer and retry traffic that drives the
  // link through its states; all fields random so every bit toggles.
  function automatic item_t rand_item();
    item_t       it;
    int unsigned sel;
    logic [15:0] half;
    sel = $urandom_range(0, 99);
    half = cf_rx_buf >> 1;
    if (sel < 35) it.command = CMD_TICK;
    else if (sel < 58) it.command = CMD_T1;
    else if (sel < 70) it.command = CMD_SET_LINK;
    else if (sel < 85) it.command = CMD_FRAME;
    else if (sel < 93) it.command = CMD_RX_BUSY;
    else it.command = 3'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
    if ($urandom_range(0, 9) == 0) it.new_state = 3'($urandom_range(LS_BAD_LO, LS_BAD_HI));
    else it.new_state = 3'($urandom_range(LS_DISCONNECTED, LS_RECOVERY));
    it.use_extended  = 1'($urandom);
    it.is_info_frame = 1'($urandom);
    case ($urandom_range(0, 3))
      0: it.rx_used = half + 16'($urandom_range(0, 2)) - 16'd1;  // around the half mark
      1: it.rx_used = 16'($urandom_range(0, 15));
      default: it.rx_used = 16'($urandom);
    endcase
    it.t1_value = 16'($urandom);
    return it;
  endfunction

  dir_row_t dir_rows[$];

  task automatic add_row(logic [2:0] cmd, logic [2:0] nst, bit ext, bit info,
                         logic [15:0] used, logic [15:0] t1v, bit typed, result_t res);
    dir_row_t row;
    row.it = '{cmd, nst, ext, info, used, t1v};
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endtask

  initial begin
    result_t     quiet_snap;
    result_t     t1_snap;
    result_t     conn_snap;
    logic [15:0] mr, dw, t3, idl;
    item_t       it;

    quiet_snap = '{FR_NONE, 1'b0, 1'b0, CLOSE_NONE, 1'b0, 1'b0, 16'h0000,
                   LS_DISCONNECTED, 1'b0, WindowRst, 5'd0, 1'b0};
    t1_snap    = '{FR_NONE, 1'b0, 1'b0, CLOSE_NONE, 1'b0, 1'b1, 16'hFFFF,
                   LS_DISCONNECTED, 1'b0, WindowRst, 5'd0, 1'b0};
    conn_snap  = '{FR_NONE, 1'b0, 1'b0, CLOSE_NONE, 1'b0, 1'b0, 16'h0000,
                   LS_CONNECTING, 1'b1, DefaultWindowRst, 5'd0, 1'b0};

    lk_state = LS_DISCONNECTED;
    lk_retry = '0;
    lk_ext = 1'b0;
    lk_window = WindowRst;
    lk_t3 = '0;
    lk_idle = '0;
    lk_rx_busy = 1'b0;
    cf_max_retries = MaxRetriesRst;
    cf_t3_period = T3PeriodRst;
    cf_idle_period = IdlePeriodRst;
    cf_default_window = DefaultWindowRst;
    cf_rx_buf = RxBufferSizeRst;
    idle_pct = 20;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Short timers and a retry limit of one so every expiry fits in the table.
    apply_settings(16'd1, 16'd3, 16'd2, 16'(DefaultWindowRst), RxBufferSizeRst);

    // Quiet link out of reset, reserved commands and a bad set-link: snapshot only.
    add_row(CMD_TICK, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, quiet_snap);
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'hFFFF, 1'b1, t1_snap);
    add_row(CMD_RSVD_HI, LS_BAD_HI, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, quiet_snap);
    add_row(CMD_RSVD_LO, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b1, quiet_snap);
    add_row(CMD_SET_LINK, LS_BAD_HI, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, quiet_snap);
    add_row(CMD_SET_LINK, LS_CONNECTING, 1'b1, 1'b0, 16'h0000, 16'h0000, 1'b1, conn_snap);
    // Extended connect: one retry, N2 out -> standard modulus, one more retry, then link failure.
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h1234, 1'b0, '0);
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h8001, 1'b0, '0);
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h00FF, 1'b0, '0);
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'hAAAA, 1'b0, '0);
    // Disconnect attempt runs out -> DISC.
    add_row(CMD_SET_LINK, LS_DISCONNECTING, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h5555, 1'b0, '0);
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0001, 1'b0, '0);
    // Connected with receive busy: full buffer keeps it, empty buffer clears it.
    add_row(CMD_SET_LINK, LS_CONNECTED, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(CMD_RX_BUSY, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(CMD_TICK, 3'd0, 1'b0, 1'b0, 16'hFFFF, 16'h0000, 1'b0, '0);
    add_row(CMD_TICK, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    // T1 while connected enters recovery, next one with N2 spent -> DM.
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h7FFF, 1'b0, '0);
    add_row(CMD_T1, 3'd0, 1'b0, 1'b0, 16'h0000, 16'hFFFE, 1'b0, '0);
    // Info frame arms T3 and idle; idle runs out first, then T3 on its own.
    add_row(CMD_SET_LINK, LS_RECOVERY, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(CMD_FRAME, 3'd0, 1'b0, 1'b1, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(CMD_TICK, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0100, 1'b0, '0);
    add_row(CMD_TICK, 3'd0, 1'b0, 1'b0, 16'h0000, 16'hC3C3, 1'b0, '0);
    add_row(CMD_TICK, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(CMD_TICK, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);
    add_row(CMD_TICK, 3'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 1'b0, '0);

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: apply_settings(16'd3, 16'd5, 16'd4, 16'd1, 16'd100);
        1: apply_settings(16'd31, 16'd0, 16'd0, 16'd127, 16'hFFFF);
        2: apply_settings(16'd1, 16'hFFFF, 16'hFFFF, 16'd64, 16'd0);
        3: apply_settings(16'd0, 16'd2, 16'd1, 16'd5, 16'd1);   // retry count wraps
        default: begin
          // junk above the register width must be dropped
          mr = 16'($urandom);
          mr[4:0] = 5'($urandom_range(1, 31));
          dw = 16'($urandom);
          dw[6:0] = 7'($urandom_range(1, 127));
          t3 = 16'($urandom_range(1, 8));
          idl = 16'($urandom_range(1, 8));
          apply_settings(mr, t3, idl, dw, 16'($urandom));
        end
      endcase
      // last phase runs flat out on both sides
      if (ph == NUM_PHASES - 1) idle_pct = 0;
      else
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 30;
        endcase
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 20) long_hold_req = 1'b1;   // back up the input side
        if (ph == 5 && k == 30) drain();                // sender pause mid-phase
        it = rand_item();
        send_item(it, 1'b0, '0);
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    $display("ran %0d commands over %0d register settings, %0d reports matched",
             items_sent, NUM_PHASES + 1, reports_ok);
    $display("seen: %0d timeout closes, %0d idle closes, %0d receive-busy clears",
             timeouts_seen, closes_seen, busy_clears);
    if (mismatches == 0 && link_report_q.size() == 0) begin
      $display("link_retry_timer_controller test passed");
    end else begin
      $display("%0d mismatches, %0d reports still owed", mismatches, link_report_q.size());
      $display("link_retry_timer_controller test failed");
    end
    $finish;
  end

endmodule
